/* rtl/ofs_pkg.sv */
// ofs_pkg: shared types, constants and register map for the overlapping frame segmenter
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package ofs_pkg;

  localparam int MAX_FRAME_DEF = 64;
  localparam int DATA_W        = 16;
  localparam int CFG_W         = 7;
  localparam int APB_AW        = 3;
  localparam int APB_DW        = 32;
  localparam int REG_IDX_W     = 1;

  localparam logic [CFG_W-1:0] FRAME_LEN_RST = 7'd64;
  localparam logic [CFG_W-1:0] HOP_LEN_RST   = 7'd32;

  localparam logic [REG_IDX_W-1:0] REG_FRAME_LEN = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_HOP_LEN   = 1'b1;

  typedef struct packed {
    logic signed [DATA_W-1:0] sample_q;
    logic signed [DATA_W-1:0] sample_i;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] out_i;
    logic signed [DATA_W-1:0] out_q;
    logic                     frame_last;
  } out_t;

  typedef struct packed {
    logic accept;
    logic issue;
    logic issue_last;
  } cmd_t;

  typedef struct packed {
    logic frame_due;
    logic credit_ok;
  } stat_t;

endpackage

`default_nettype wire

/* rtl/ofs_regs.sv */
// ofs_regs: apb register file holding frame length and hop, with range clamping
// depends on ofs_pkg
`timescale 1ns / 1ps
`default_nettype none

module ofs_regs #(
  parameter int MAX_FRAME = ofs_pkg::MAX_FRAME_DEF,
  parameter int CNT_W     = $clog2(MAX_FRAME + 1)
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [ofs_pkg::APB_AW-1:0] paddr,
  input  wire logic [ofs_pkg::APB_DW-1:0] pwdata,
  output logic      [ofs_pkg::APB_DW-1:0] prdata,
  output logic                            pready,
  output logic      [CNT_W-1:0]           flen_eff,
  output logic      [CNT_W-1:0]           hop_eff
);
  import ofs_pkg::*;

  logic [CFG_W-1:0]     frame_len;
  logic [CFG_W-1:0]     hop_len;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;
  logic [CFG_W-1:0]     flen_c;
  logic [CFG_W-1:0]     hop_c;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_AW-1:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_len <= FRAME_LEN_RST;
      hop_len   <= HOP_LEN_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_FRAME_LEN: frame_len <= pwdata[CFG_W-1:0];
        REG_HOP_LEN:   hop_len   <= pwdata[CFG_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FRAME_LEN: prdata = APB_DW'(frame_len);
      REG_HOP_LEN:   prdata = APB_DW'(hop_len);
    endcase
  end

  // clamp to the usable range
  always_comb begin
    priority if (frame_len == '0) flen_c = CFG_W'(1);
    else if (frame_len > CFG_W'(MAX_FRAME)) flen_c = CFG_W'(MAX_FRAME);
    else flen_c = frame_len;

    priority if (hop_len == '0) hop_c = CFG_W'(1);
    else if (hop_len > flen_c) hop_c = flen_c;
    else hop_c = hop_len;
  end

  assign flen_eff = flen_c[CNT_W-1:0];
  assign hop_eff  = hop_c[CNT_W-1:0];

endmodule

`default_nettype wire

/* rtl/ofs_ctrl.sv */
// ofs_ctrl: controller fsm, takes samples and sequences the frame read-out
// depends on ofs_pkg; drives the datapath through cmd_t, watches stat_t
`timescale 1ns / 1ps
`default_nettype none

module ofs_ctrl #(
  parameter int MAX_FRAME = ofs_pkg::MAX_FRAME_DEF,
  parameter int PTR_W     = $clog2(MAX_FRAME),
  parameter int CNT_W     = $clog2(MAX_FRAME + 1)
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 sample_valid,
  output logic                      sample_ready,
  input  wire logic [CNT_W-1:0]     flen_eff,
  input  wire ofs_pkg::stat_t       stat,
  output ofs_pkg::cmd_t             cmd
);
  import ofs_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic [0:0]       state;
  logic [0:0]       state_next;
  logic [PTR_W-1:0] k;
  logic [PTR_W-1:0] k_next;

  assign sample_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    k_next     = k;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        cmd.accept = sample_valid;
        if (sample_valid && stat.frame_due) begin
          state_next = ST_READ;
          k_next     = '0;
        end
      end
      ST_READ: begin
        if (stat.credit_ok) begin
          cmd.issue      = 1'b1;
          cmd.issue_last = (CNT_W'(k) == flen_eff - CNT_W'(1));
          if (cmd.issue_last) begin
            state_next = ST_IDLE;
          end else begin
            k_next = k + PTR_W'(1);
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      k     <= '0;
    end else begin
      state <= state_next;
      k     <= k_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/ofs_dp.sv */
// ofs_dp: datapath with sample ring store, pointers, fill count and output buffer
// depends on ofs_pkg; commanded by ofs_ctrl
`timescale 1ns / 1ps
`default_nettype none

module ofs_dp #(
  parameter int MAX_FRAME = ofs_pkg::MAX_FRAME_DEF,
  parameter int PTR_W     = $clog2(MAX_FRAME),
  parameter int CNT_W     = $clog2(MAX_FRAME + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire ofs_pkg::in_t     sample,
  output ofs_pkg::out_t         result,
  output logic                  result_valid,
  input  wire logic             result_ready,
  input  wire logic [CNT_W-1:0] flen_eff,
  input  wire logic [CNT_W-1:0] hop_eff,
  input  wire ofs_pkg::cmd_t    cmd,
  output ofs_pkg::stat_t        stat
);
  import ofs_pkg::*;

  function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] p,
                                                input logic [CNT_W-1:0] n);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(p) + (CNT_W+1)'(n);
    if (s >= (CNT_W+1)'(MAX_FRAME)) s = s - (CNT_W+1)'(MAX_FRAME);
    return s[PTR_W-1:0];
  endfunction

  in_t              mem [MAX_FRAME];
  in_t              rd_data;
  logic             rd_last;
  logic             pend;
  logic [PTR_W-1:0] write_ptr;
  logic [PTR_W-1:0] oldest_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill_count;
  logic [CNT_W-1:0] fill_after;
  logic [PTR_W-1:0] oldest_after;
  logic             store_full;

  out_t             obuf [2];
  logic             head;
  logic             tail;
  logic [1:0]       ocnt;
  logic             push;
  logic             pop;
  logic [2:0]       used;

  // store
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mem[write_ptr] <= sample;
    end
    if (cmd.issue) begin
      rd_data <= mem[rd_ptr];
      rd_last <= cmd.issue_last;
    end
  end

  assign store_full   = (fill_count == CNT_W'(MAX_FRAME));
  assign fill_after   = store_full ? fill_count : fill_count + CNT_W'(1);
  assign oldest_after = store_full ? ring_add(oldest_ptr, CNT_W'(1)) : oldest_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      write_ptr  <= '0;
      oldest_ptr <= '0;
      rd_ptr     <= '0;
      fill_count <= '0;
      pend       <= 1'b0;
    end else begin
      pend <= cmd.issue;
      if (cmd.accept) begin
        write_ptr  <= ring_add(write_ptr, CNT_W'(1));
        fill_count <= fill_after;
        oldest_ptr <= oldest_after;
        rd_ptr     <= oldest_after;
      end
      if (cmd.issue) begin
        rd_ptr <= ring_add(rd_ptr, CNT_W'(1));
      end
      if (cmd.issue_last) begin
        oldest_ptr <= ring_add(oldest_ptr, hop_eff);
        fill_count <= fill_count - hop_eff;
      end
    end
  end

  // output buffer, two entries
  assign push         = pend;
  assign result_valid = (ocnt != 2'd0);
  assign pop          = result_valid && result_ready;
  assign result       = obuf[head];
  assign used         = 3'(ocnt) + 3'(pend);

  always_ff @(posedge clk) begin
    if (push) begin
      obuf[tail] <= '{out_i: rd_data.sample_i, out_q: rd_data.sample_q,
                      frame_last: rd_last};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= 1'b0;
      tail <= 1'b0;
      ocnt <= 2'd0;
    end else begin
      if (push) tail <= ~tail;
      if (pop) head <= ~head;
      ocnt <= ocnt + 2'(push) - 2'(pop);
    end
  end

  assign stat.frame_due = (fill_after >= flen_eff);
  assign stat.credit_ok = (used < 3'd2 + 3'(pop));

endmodule

`default_nettype wire

/* rtl/overlapping_frame_segmenter.sv */
// overlapping_frame_segmenter: top level, joins register file, controller and datapath
// depends on ofs_pkg, ofs_regs, ofs_ctrl, ofs_dp
//
//   channel   direction  handshake                      payload
//   sample    in         sample_valid / sample_ready    ofs_pkg::in_t
//   result    out        result_valid / result_ready    ofs_pkg::out_t
//   apb       in         psel, penable, pready          paddr, pwdata, prdata
//
// samples are taken in idle; once a frame is due, the next waits for its read-out:
// the frame is read from the single-port ring store one entry per cycle
// stalls on the result side pause the read-out through a two-entry output buffer
// synchronous reset; store contents are not cleared, no clearing pass is needed
`timescale 1ns / 1ps
`default_nettype none

module overlapping_frame_segmenter #(
  parameter int MAX_FRAME = ofs_pkg::MAX_FRAME_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire ofs_pkg::in_t               sample,
  input  wire logic                       sample_valid,
  output logic                            sample_ready,
  output ofs_pkg::out_t                   result,
  output logic                            result_valid,
  input  wire logic                       result_ready,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [ofs_pkg::APB_AW-1:0] paddr,
  input  wire logic [ofs_pkg::APB_DW-1:0] pwdata,
  output logic      [ofs_pkg::APB_DW-1:0] prdata,
  output logic                            pready
);
  import ofs_pkg::*;

  localparam int PTR_W = $clog2(MAX_FRAME);
  localparam int CNT_W = $clog2(MAX_FRAME + 1);

  logic [CNT_W-1:0] flen_eff;
  logic [CNT_W-1:0] hop_eff;
  cmd_t             cmd;
  stat_t            stat;

  ofs_regs #(
    .MAX_FRAME (MAX_FRAME),
    .CNT_W     (CNT_W)
  ) u_regs (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .flen_eff (flen_eff),
    .hop_eff  (hop_eff)
  );

  ofs_ctrl #(
    .MAX_FRAME (MAX_FRAME),
    .PTR_W     (PTR_W),
    .CNT_W     (CNT_W)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .flen_eff     (flen_eff),
    .stat         (stat),
    .cmd          (cmd)
  );

  ofs_dp #(
    .MAX_FRAME (MAX_FRAME),
    .PTR_W     (PTR_W),
    .CNT_W     (CNT_W)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .sample       (sample),
    .result       (result),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .flen_eff     (flen_eff),
    .hop_eff      (hop_eff),
    .cmd          (cmd),
    .stat         (stat)
  );

endmodule

`default_nettype wire

/* tb/tb_overlapping_frame_segmenter.sv */
// tb_overlapping_frame_segmenter: self-checking testbench for the overlapping frame segmenter
// streams samples, predicts every frame sample from a ring copy and checks each result transaction
// depends on ofs_pkg and overlapping_frame_segmenter
`timescale 1ns / 1ps

module tb_overlapping_frame_segmenter;
  import ofs_pkg::*;

  localparam int FRAMES_MAX   = MAX_FRAME_DEF;
  localparam int PTR_W        = $clog2(MAX_FRAME_DEF);
  localparam int RUN_LIMIT_NS = 6000000;
  localparam int PRINT_CAP    = 40;
  localparam int EXPECT_DEPTH = 4096;

  logic              clk;
  logic              rst;
  in_t               sample;
  logic              sample_valid;
  logic              sample_ready;
  out_t              result;
  logic              result_valid;
  logic              result_ready;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  // ring copy of the stored samples and the settings in force
  in_t              ring_copy [FRAMES_MAX];
  logic [PTR_W-1:0] oldest_idx;
  logic [PTR_W-1:0] write_idx;
  int unsigned      stored;
  logic [CFG_W-1:0] frame_len_reg;
  logic [CFG_W-1:0] hop_len_reg;

  // expected frame samples, oldest at expect_rd
  out_t        expect_mem [EXPECT_DEPTH];
  int unsigned expect_wr;
  int unsigned expect_rd;
  out_t        next_expected;
  int          err_count;
  int          samples_in;
  int          samples_checked;
  int          frames_done;
  int          settings_used;
  bit          idling_on;

  overlapping_frame_segmenter u_top (
    .clk          (clk),
    .rst          (rst),
    .sample       (sample),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .result       (result),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int unsigned expect_count();
    return expect_wr - expect_rd;
  endfunction

  function automatic void expect_add(input out_t e);
    expect_mem[expect_wr % EXPECT_DEPTH] = e;
    expect_wr++;
  endfunction

  function automatic out_t expect_take();
    out_t e;
    e = expect_mem[expect_rd % EXPECT_DEPTH];
    expect_rd++;
    return e;
  endfunction

  initial begin
    #RUN_LIMIT_NS;
    $display("timeout: %0d frame samples still outstanding", expect_count());
    $display("DONE: errors detected");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    if (err_count < PRINT_CAP) begin
      $display("mismatch at %0t ns: %s", $time, msg);
    end
    err_count++;
  endtask

  // store one sample and queue the frame it releases, if any
  function automatic void segment_frames(input in_t s);
    int unsigned      flen;
    int unsigned      hop;
    logic [PTR_W-1:0] idx;
    out_t             e;
    flen = frame_len_reg;
    if (flen < 1) flen = 1;
    if (flen > FRAMES_MAX) flen = FRAMES_MAX;
    hop = hop_len_reg;
    if (hop < 1) hop = 1;
    if (hop > flen) hop = flen;
    ring_copy[write_idx] = s;
    write_idx = write_idx + 1'b1;
    if (stored < FRAMES_MAX) stored++;
    else oldest_idx = oldest_idx + 1'b1;
    if (stored >= flen) begin
      for (int k = 0; k < flen; k++) begin
        idx          = oldest_idx + PTR_W'(k);
        e.out_i      = ring_copy[idx].sample_i;
        e.out_q      = ring_copy[idx].sample_q;
        e.frame_last = (k == flen - 1);
        expect_add(e);
      end
      oldest_idx = oldest_idx + PTR_W'(hop);
      stored     = stored - hop;
    end
  endfunction

  function automatic in_t rand_sample();
    in_t s;
    s = in_t'($urandom);
    if ($urandom_range(0, 7) == 0) s.sample_i = ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7FFF;
    if ($urandom_range(0, 7) == 0) s.sample_q = ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7FFF;
    return s;
  endfunction

  // accepted sample transactions feed the predictor
  always @(posedge clk) begin
    if (!rst && sample_valid && sample_ready) begin
      segment_frames(sample);
      samples_in++;
    end
  end

  // every accepted result transaction against the oldest expected frame sample
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (expect_count() == 0) begin
        report_mismatch($sformatf("unexpected frame sample i=%h q=%h last=%b",
                                  result.out_i, result.out_q, result.frame_last));
      end else begin
        next_expected = expect_take();
        if (result.out_i !== next_expected.out_i)
          report_mismatch($sformatf("out_i %h, expected %h", result.out_i, next_expected.out_i));
        if (result.out_q !== next_expected.out_q)
          report_mismatch($sformatf("out_q %h, expected %h", result.out_q, next_expected.out_q));
        if (result.frame_last !== next_expected.frame_last)
          report_mismatch($sformatf("frame_last %b, expected %b",
                                    result.frame_last, next_expected.frame_last));
        if (next_expected.frame_last) frames_done++;
      end
      samples_checked++;
    end
  end

  // result side back-pressure
  initial begin
    result_ready = 1'b1;
    forever begin
      @(posedge clk);
      if (idling_on && $urandom_range(0, 7) == 0) begin
        result_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      result_ready <= 1'b1;
    end
  end

  task automatic send_sample(input in_t s);
    if (idling_on && $urandom_range(0, 7) == 0) begin
      sample_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    sample       <= s;
    sample_valid <= 1'b1;
    do @(posedge clk); while (!sample_ready);
  endtask

  task automatic send_random(input int count);
    repeat (count) send_sample(rand_sample());
  endtask

  // stop sending and let every outstanding frame drain
  task automatic wait_for_frames();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (expect_count() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'({idx, 2'b00});
    pwdata  <= APB_DW'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_FRAME_LEN) frame_len_reg = val;
    else hop_len_reg = val;
    @(posedge clk);
  endtask

  task automatic reg_check(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    logic [APB_DW-1:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= APB_AW'({idx, 2'b00});
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== APB_DW'(val))
      report_mismatch($sformatf("register %0d reads %h, expected %h", idx, rd, val));
    @(posedge clk);
  endtask

  task automatic apply_setting(input logic [CFG_W-1:0] flen, input logic [CFG_W-1:0] hop);
    reg_write(REG_FRAME_LEN, flen);
    reg_write(REG_HOP_LEN, hop);
    reg_check(REG_FRAME_LEN, flen);
    reg_check(REG_HOP_LEN, hop);
    settings_used++;
  endtask

  task automatic test_reset_values();
    reg_check(REG_FRAME_LEN, FRAME_LEN_RST);
    reg_check(REG_HOP_LEN, HOP_LEN_RST);
    send_random(70);
    wait_for_frames();
  endtask

  task automatic test_extreme_samples();
    apply_setting(7'd4, 7'd2);
    send_sample(in_t'({16'h7FFF, 16'h8000}));
    send_sample(in_t'({16'h8000, 16'h7FFF}));
    send_sample(in_t'({16'hFFFF, 16'h0000}));
    send_sample(in_t'({16'h0000, 16'hFFFF}));
    send_sample(in_t'({16'hAAAA, 16'h5555}));
    send_sample(in_t'({16'h5555, 16'hAAAA}));
    send_sample(in_t'({16'hFFFE, 16'h0001}));
    send_sample(in_t'({16'h8000, 16'h8000}));
    wait_for_frames();
  endtask

  task automatic test_out_of_range_settings();
    // zero frame and zero hop act as one
    apply_setting(7'd0, 7'd0);
    send_random(4);
    wait_for_frames();
    // hop beyond the frame is clamped to the frame
    apply_setting(7'd3, 7'd127);
    send_random(6);
    wait_for_frames();
    // frame beyond the store is clamped to the store size
    apply_setting(7'd127, 7'd127);
    send_random(70);
    wait_for_frames();
    apply_setting(7'd65, 7'd0);
    send_random(30);
    wait_for_frames();
  endtask

  task automatic test_heavy_overlap();
    apply_setting(7'd64, 7'd1);
    send_random(40);
    wait_for_frames();
    apply_setting(7'd1, 7'd1);
    send_random(40);
    wait_for_frames();
  endtask

  task automatic test_random_settings();
    logic [CFG_W-1:0] flen;
    logic [CFG_W-1:0] hop;
    for (int p = 0; p < 4; p++) begin
      flen = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom_range(0, 127))
                                         : CFG_W'($urandom_range(1, 16));
      hop  = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom_range(0, 127))
                                         : CFG_W'($urandom_range(1, flen));
      idling_on = (p != 2);
      apply_setting(flen, hop);
      send_random(30);
      wait_for_frames();
    end
    idling_on = 1'b1;
  endtask

  task automatic test_back_to_back();
    idling_on = 1'b0;
    apply_setting(CFG_W'($urandom_range(1, 12)), CFG_W'($urandom_range(1, 12)));
    send_random(40);
    wait_for_frames();
  endtask

  initial begin
    rst             = 1'b1;
    sample          = '0;
    sample_valid    = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    oldest_idx      = '0;
    write_idx       = '0;
    stored          = 0;
    expect_wr       = 0;
    expect_rd       = 0;
    frame_len_reg   = FRAME_LEN_RST;
    hop_len_reg     = HOP_LEN_RST;
    err_count       = 0;
    samples_in      = 0;
    samples_checked = 0;
    frames_done     = 0;
    settings_used   = 1;
    idling_on       = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_values();
    test_extreme_samples();
    test_out_of_range_settings();
    test_heavy_overlap();
    test_random_settings();
    test_back_to_back();

    $display("covered %0d samples in, %0d frame samples in %0d frames, %0d register settings",
             samples_in, samples_checked, frames_done, settings_used);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches", err_count);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
